// ===== rtl/sorted_list_insert_remove_defines.svh =====
// assertion macros for the sorted list block
`ifndef SORTED_LIST_INSERT_REMOVE_DEFINES_SVH
`define SORTED_LIST_INSERT_REMOVE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define SLI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SLI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sli_pkg.sv =====
`timescale 1ns / 1ps
package sli_pkg;

	localparam int VALUE_W      = 32;
	localparam int INDEX_W      = 6;
	localparam int COUNT_OUT_W  = 7;
	localparam int STATUS_W     = 3;
	localparam int CAPACITY_DEF = 64;
	localparam int IDX_CMP_W    = 16;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_READ   = 2'd2,
		REQ_NOP    = 2'd3
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

	typedef struct packed {
		req_type_t                   req_type;
		logic signed [VALUE_W-1:0]   value;
		logic        [INDEX_W-1:0]   index;
	} sli_req_t;

	typedef struct packed {
		status_t                      status;
		logic        [COUNT_OUT_W-1:0] entry_count;
		logic        [INDEX_W-1:0]   position;
		logic signed [VALUE_W-1:0]   read_value;
	} sli_rsp_t;

	// per-beat command broadcast to every cell
	typedef struct packed {
		logic               ins;
		logic               rem;
		logic               rd;
		logic [INDEX_W-1:0] idx;
	} cell_ctl_t;

	// compare flags seen by the right-hand neighbor and by the top
	typedef struct packed {
		logic valid;
		logic gt;
		logic eq;
	} cell_flags_t;

	// per-cell hit flags collected by the top
	typedef struct packed {
		logic pos;
		logic rd;
	} cell_hit_t;

endpackage

// ===== rtl/sli_cell.sv =====
`timescale 1ns / 1ps
module sli_cell import sli_pkg::*; #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  logic                      clk,
	input  logic                      en,
	input  cell_ctl_t                 ctl,
	input  logic        [CW-1:0]      count,
	input  logic signed [VALUE_W-1:0] value,
	input  logic signed [VALUE_W-1:0] left_data,
	input  cell_flags_t               left_flags,
	input  logic signed [VALUE_W-1:0] right_data,
	output logic signed [VALUE_W-1:0] data,
	output cell_flags_t               flags,
	output cell_hit_t                 hit
);

	logic signed [VALUE_W-1:0] data_q;
	logic valid;
	logic lt;
	logic take_val;
	logic first;

	assign valid = CW'(IDX) < count;
	assign lt    = valid && (data_q < value);

	assign flags.valid = valid;
	assign flags.gt    = valid && (data_q > value);
	assign flags.eq    = valid && (data_q == value);

	// boundary cell: first one above the value or past the end
	assign take_val = (flags.gt || !valid) && left_flags.valid && !left_flags.gt;
	assign first    = flags.eq && !left_flags.eq;

	always_ff @(posedge clk) begin
		if (en && ctl.ins) begin
			if (left_flags.gt) begin
				data_q <= left_data;
			end else if (take_val) begin
				data_q <= value;
			end
		end else if (en && ctl.rem) begin
			if (valid && !lt) begin
				data_q <= right_data;
			end
		end
	end

	assign data    = data_q;
	assign hit.pos = (ctl.ins && take_val) || (ctl.rem && first);
	assign hit.rd  = ctl.rd && (IDX_CMP_W'(IDX) == IDX_CMP_W'(ctl.idx));

endmodule

// ===== rtl/sorted_list_insert_remove.sv =====
`timescale 1ns / 1ps
`include "sorted_list_insert_remove_defines.svh"
// sorted list of signed values, up to CAPACITY entries, held in a row of cells
// usage:
//   drive req and pulse start; a beat is taken at a clock edge with start high and
//   busy low. req_type selects insert, remove or read at index.
//   each beat gives one result on rsp, valid for exactly one cycle while done is
//   high; the receiver cannot hold it off and must take it then.
// done rises after the accepting edge once the beat has passed compare and shift
//   in the row, then hit collection into the output register.
// busy stays high for the cycle in which every cell compares against the value
//   and shifts with its neighbor; no beat is taken while busy is high, and the
//   next beat already sees the updated list.
// insert keeps ascending order and goes after equal entries; a full list drops
//   the value with status full. remove takes out the first equal entry.
// rsp reports status, entry count after the beat, affected position and any
//   read value; position and read value are zero unless they apply.
// reset: the entry count clears and nothing is pending; cell contents stay
//   undefined and are never read before being written.
module sorted_list_insert_remove import sli_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  sli_req_t req,
	output logic     done,
	output sli_rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = $clog2(CAPACITY);

	logic      v_s1;
	sli_req_t  req_s1;
	logic      v_s2;
	status_t   status_s2;
	logic [CAPACITY-1:0] pos_hot_s2;
	logic [CAPACITY-1:0] rd_hot_s2;
	logic [CW-1:0] count_q;
	logic      done_q;
	sli_rsp_t  rsp_q;

	logic signed [VALUE_W-1:0] cell_data [CAPACITY];
	cell_flags_t cell_flags [CAPACITY];
	cell_hit_t   cell_hit [CAPACITY];
	logic [CAPACITY-1:0] eq_vec;
	logic [CAPACITY-1:0] pos_hot;
	logic [CAPACITY-1:0] rd_hot;

	cell_ctl_t ctl;
	logic found;
	logic full;
	logic empty;
	logic in_range;
	status_t status;
	logic [PW-1:0] pos_sum;
	logic signed [VALUE_W-1:0] rd_sum;

	assign busy = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	assign found    = |eq_vec;
	assign full     = count_q == CW'(CAPACITY);
	assign empty    = count_q == '0;
	assign in_range = IDX_CMP_W'(req_s1.index) < IDX_CMP_W'(count_q);

	always_comb begin
		status = ST_OK;
		ctl    = '0;
		ctl.idx = req_s1.index;
		unique case (req_s1.req_type)
			REQ_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					ctl.ins = 1'b1;
				end
			end
			REQ_REMOVE: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (!found) begin
					status = ST_NOT_FOUND;
				end else begin
					ctl.rem = 1'b1;
				end
			end
			REQ_READ: begin
				if (in_range) begin
					ctl.rd = 1'b1;
				end else begin
					status = ST_RANGE;
				end
			end
			REQ_NOP: begin
				status = ST_OK;
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_W-1:0] l_data;
		logic signed [VALUE_W-1:0] r_data;
		cell_flags_t l_flags;

		if (i == 0) begin : g_head
			assign l_data  = req_s1.value;
			assign l_flags = '{valid: 1'b1, gt: 1'b0, eq: 1'b0};
		end else begin : g_body
			assign l_data  = cell_data[i-1];
			assign l_flags = cell_flags[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign r_data = cell_data[i];
		end else begin : g_mid
			assign r_data = cell_data[i+1];
		end

		sli_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.en         (v_s1),
			.ctl        (ctl),
			.count      (count_q),
			.value      (req_s1.value),
			.left_data  (l_data),
			.left_flags (l_flags),
			.right_data (r_data),
			.data       (cell_data[i]),
			.flags      (cell_flags[i]),
			.hit        (cell_hit[i])
		);

		assign eq_vec[i]  = cell_flags[i].eq;
		assign pos_hot[i] = cell_hit[i].pos;
		assign rd_hot[i]  = cell_hit[i].rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			v_s2    <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			if (v_s1 && ctl.ins) begin
				count_q <= count_q + CW'(1);
			end else if (v_s1 && ctl.rem) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			status_s2  <= status;
			pos_hot_s2 <= pos_hot;
			rd_hot_s2  <= rd_hot;
		end
	end

	// one-hot to index and masked read collection
	always_comb begin
		pos_sum = '0;
		rd_sum  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			pos_sum = pos_sum | (pos_hot_s2[i] ? PW'(i) : PW'(0));
			rd_sum  = rd_sum | (cell_data[i] & {VALUE_W{rd_hot_s2[i]}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			rsp_q.status      <= status_s2;
			rsp_q.entry_count <= COUNT_OUT_W'(count_q);
			rsp_q.position    <= INDEX_W'(pos_sum);
			rsp_q.read_value  <= rd_sum;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`SLI_ASSERT_IMP(a_count_cap, 1'b1, count_q <= CW'(CAPACITY), "entry count above capacity")
	`SLI_ASSERT_IMP(a_ins_onehot, v_s1 && ctl.ins, $onehot(pos_hot), "insert slot not unique")
	`SLI_ASSERT_IMP(a_rd_onehot, v_s1, $onehot0(rd_hot), "more than one cell read")
	`SLI_ASSERT_NXT(a_full_count, v_s1 && status == ST_FULL, count_q == CW'(CAPACITY),
		"full reported below capacity")

endmodule
